// ----- rtl/slotalloc_pkg.sv -----
// ----------------------------------------------------------------------------
// Slot allocator package
// Shared types, codes and reset values for the slot allocator.
// ----------------------------------------------------------------------------
package slotalloc_pkg;

    localparam int MAX_SLOTS_DEF = 1024;

    localparam int CFG_W    = 16;
    localparam int SLOT_W   = 11;
    localparam int INDEX_W  = 10;
    localparam int SERIAL_W = 16;
    localparam int TIME_W   = 32;
    localparam int MS_W     = 16;

    localparam logic [SLOT_W-1:0] FIRST_SLOT_RST  = 11'd1;
    localparam logic [SLOT_W-1:0] SLOT_LIMIT_RST  = 11'd1024;
    localparam logic [MS_W-1:0]   GRACE_RST       = 16'd2000;
    localparam logic [MS_W-1:0]   REUSE_DELAY_RST = 16'd500;

    typedef enum logic [1:0] {
        CFG_FIRST_ALLOC_SLOT = 2'd0,
        CFG_SLOT_LIMIT       = 2'd1,
        CFG_GRACE_MS         = 2'd2,
        CFG_REUSE_DELAY_MS   = 2'd3
    } cfg_reg_t;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        STAT_OK           = 3'd0,
        STAT_ALREADY_FREE = 3'd1,
        STAT_NO_CAPACITY  = 3'd2,
        STAT_TABLE_FULL   = 3'd3,
        STAT_BAD_INDEX    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_CHK,
        S_RESP
    } state_t;

    typedef struct packed {
        logic                is_free;
        logic [SERIAL_W-1:0] serial;
        logic [TIME_W-1:0]   freed_at;
    } entry_t;

endpackage

// ----- rtl/slot_allocator_with_reuse_delay.sv -----
// ----------------------------------------------------------------------------
// Slot allocator with reuse delay
// First-fit slot table with per-slot serials and a rest time before reuse.
// ----------------------------------------------------------------------------
// A free reads its slot when taken and checks it in S_FREE_CHK; a bad index goes
// straight to S_RESP. An allocate reads one slot per cycle from first_alloc_slot
// in S_SCAN and stops at the first reusable slot or at the high-water mark.
// One transaction is in work at a time; s_ready rises in the cycle in which the
// result first sits in the output register. After reset the slot memory is
// cleared slot by slot, during which s_ready stays low.
module slot_allocator_with_reuse_delay #(
    parameter int MAX_SLOTS = slotalloc_pkg::MAX_SLOTS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [9:0]  s_slot_index,
    input  logic [31:0] s_now_ms,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [9:0]  m_granted_slot,
    output logic [15:0] m_slot_serial,
    output logic [2:0]  m_status
);

    localparam int IDX_W = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MAX_SLOTS - 1);

    slotalloc_pkg::state_t state_reg, state_next;

    logic [10:0] first_slot_reg;
    logic [10:0] slot_limit_reg;
    logic [15:0] grace_reg;
    logic [15:0] reuse_delay_reg;

    logic [10:0] hw_reg, hw_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [9:0]  idx_reg, idx_next;
    logic [31:0] now_reg, now_next;
    logic [10:0] cnt_reg, cnt_next;
    logic        pend_reg, pend_next;
    logic [10:0] paddr_reg, paddr_next;

    logic [9:0]  res_slot_reg, res_slot_next;
    logic [15:0] res_serial_reg, res_serial_next;
    slotalloc_pkg::status_t res_status_reg, res_status_next;

    logic        m_valid_reg, m_valid_next;
    logic [9:0]  m_slot_reg, m_slot_next;
    logic [15:0] m_serial_reg, m_serial_next;
    slotalloc_pkg::status_t m_status_reg, m_status_next;

    slotalloc_pkg::entry_t slot_mem [MAX_SLOTS];
    slotalloc_pkg::entry_t rdata_reg;
    slotalloc_pkg::entry_t mem_wdata;
    logic             mem_we;
    logic             mem_re;
    logic [IDX_W-1:0] mem_waddr;
    logic [IDX_W-1:0] mem_raddr;

    logic        s_accept;
    logic        out_free;
    logic        scan_more;
    logic        reusable;
    logic        scan_hit;
    logic        scan_done;
    logic        bad_index;
    logic [10:0] append_idx;
    logic        append_full;

    assign s_ready        = (state_reg == slotalloc_pkg::S_IDLE);
    assign s_accept       = s_valid && s_ready;
    assign out_free       = !m_valid_reg || m_ready;
    assign m_valid        = m_valid_reg;
    assign m_granted_slot = m_slot_reg;
    assign m_slot_serial  = m_serial_reg;
    assign m_status       = m_status_reg;

    assign scan_more = cnt_reg < hw_reg;
    assign reusable  = rdata_reg.is_free &&
                       ((rdata_reg.freed_at < {16'b0, grace_reg}) ||
                        ({1'b0, now_reg} > ({1'b0, rdata_reg.freed_at} +
                                            {17'b0, reuse_delay_reg})));
    assign scan_hit  = pend_reg && reusable;
    assign scan_done = !pend_reg && !scan_more;
    assign bad_index = {1'b0, s_slot_index} >= hw_reg;

    assign append_idx  = (hw_reg > first_slot_reg) ? hw_reg : first_slot_reg;
    assign append_full = (append_idx >= slot_limit_reg) ||
                         ({21'b0, append_idx} >= 32'(MAX_SLOTS));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= slot_mem[mem_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_slot_reg  <= slotalloc_pkg::FIRST_SLOT_RST;
            slot_limit_reg  <= slotalloc_pkg::SLOT_LIMIT_RST;
            grace_reg       <= slotalloc_pkg::GRACE_RST;
            reuse_delay_reg <= slotalloc_pkg::REUSE_DELAY_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                slotalloc_pkg::CFG_FIRST_ALLOC_SLOT: first_slot_reg  <= cfg_wr_data[10:0];
                slotalloc_pkg::CFG_SLOT_LIMIT:       slot_limit_reg  <= cfg_wr_data[10:0];
                slotalloc_pkg::CFG_GRACE_MS:         grace_reg       <= cfg_wr_data;
                slotalloc_pkg::CFG_REUSE_DELAY_MS:   reuse_delay_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= slotalloc_pkg::S_CLEAR;
            hw_reg      <= '0;
            clr_reg     <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            hw_reg      <= hw_next;
            clr_reg     <= clr_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        now_reg        <= now_next;
        cnt_reg        <= cnt_next;
        paddr_reg      <= paddr_next;
        res_slot_reg   <= res_slot_next;
        res_serial_reg <= res_serial_next;
        res_status_reg <= res_status_next;
        m_slot_reg     <= m_slot_next;
        m_serial_reg   <= m_serial_next;
        m_status_reg   <= m_status_next;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            slotalloc_pkg::S_CLEAR: begin
                if (clr_reg == CLR_LAST) begin
                    state_next = slotalloc_pkg::S_IDLE;
                end
            end
            slotalloc_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (s_func == slotalloc_pkg::FUNC_ALLOC) begin
                        state_next = slotalloc_pkg::S_SCAN;
                    end else if (bad_index) begin
                        state_next = slotalloc_pkg::S_RESP;
                    end else begin
                        state_next = slotalloc_pkg::S_FREE_CHK;
                    end
                end
            end
            slotalloc_pkg::S_SCAN: begin
                if (scan_hit || scan_done) begin
                    state_next = slotalloc_pkg::S_RESP;
                end
            end
            slotalloc_pkg::S_FREE_CHK: begin
                state_next = slotalloc_pkg::S_RESP;
            end
            slotalloc_pkg::S_RESP: begin
                if (out_free) begin
                    state_next = slotalloc_pkg::S_IDLE;
                end
            end
            default: state_next = slotalloc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        hw_next         = hw_reg;
        clr_next        = clr_reg;
        idx_next        = idx_reg;
        now_next        = now_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        paddr_next      = paddr_reg;
        res_slot_next   = res_slot_reg;
        res_serial_next = res_serial_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_slot_next     = m_slot_reg;
        m_serial_next   = m_serial_reg;
        m_status_next   = m_status_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = '0;
        mem_raddr       = '0;
        mem_wdata       = rdata_reg;

        case (state_reg)
            slotalloc_pkg::S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + IDX_W'(1);
            end
            slotalloc_pkg::S_IDLE: begin
                if (s_accept) begin
                    idx_next  = s_slot_index;
                    now_next  = s_now_ms;
                    cnt_next  = first_slot_reg;
                    pend_next = 1'b0;
                    if (s_func == slotalloc_pkg::FUNC_FREE) begin
                        if (bad_index) begin
                            res_slot_next   = '0;
                            res_serial_next = '0;
                            res_status_next = slotalloc_pkg::STAT_BAD_INDEX;
                        end else begin
                            mem_re    = 1'b1;
                            mem_raddr = IDX_W'(s_slot_index);
                        end
                    end
                end
            end
            slotalloc_pkg::S_SCAN: begin
                if (scan_hit) begin
                    mem_we            = 1'b1;
                    mem_waddr         = IDX_W'(paddr_reg);
                    mem_wdata.is_free = 1'b0;
                    res_slot_next     = 10'(paddr_reg);
                    res_serial_next   = rdata_reg.serial;
                    res_status_next   = slotalloc_pkg::STAT_OK;
                end else if (scan_done) begin
                    // Slots at or above the high-water mark still hold their
                    // cleared contents, so an appended slot has serial zero.
                    res_slot_next   = '0;
                    res_serial_next = '0;
                    if (slot_limit_reg == '0) begin
                        res_status_next = slotalloc_pkg::STAT_NO_CAPACITY;
                    end else if (append_full) begin
                        res_status_next = slotalloc_pkg::STAT_TABLE_FULL;
                    end else begin
                        hw_next         = append_idx + 11'd1;
                        res_slot_next   = 10'(append_idx);
                        res_status_next = slotalloc_pkg::STAT_OK;
                    end
                end else begin
                    pend_next = scan_more;
                    if (scan_more) begin
                        mem_re     = 1'b1;
                        mem_raddr  = IDX_W'(cnt_reg);
                        paddr_next = cnt_reg;
                        cnt_next   = cnt_reg + 11'd1;
                    end
                end
            end
            slotalloc_pkg::S_FREE_CHK: begin
                res_slot_next = idx_reg;
                if (rdata_reg.is_free) begin
                    res_serial_next = rdata_reg.serial;
                    res_status_next = slotalloc_pkg::STAT_ALREADY_FREE;
                end else begin
                    mem_we             = 1'b1;
                    mem_waddr          = IDX_W'(idx_reg);
                    mem_wdata.is_free  = 1'b1;
                    mem_wdata.serial   = rdata_reg.serial + 16'd1;
                    mem_wdata.freed_at = now_reg;
                    res_serial_next    = rdata_reg.serial + 16'd1;
                    res_status_next    = slotalloc_pkg::STAT_OK;
                end
            end
            slotalloc_pkg::S_RESP: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = res_slot_reg;
                    m_serial_next = res_serial_reg;
                    m_status_next = res_status_reg;
                end
            end
            default: ;
        endcase
    end

    a_hw_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        {21'b0, hw_reg} <= 32'(MAX_SLOTS))
        else $error("High-water mark exceeds the slot table.");

    a_hw_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> hw_reg >= $past(hw_reg))
        else $error("High-water mark decreased.");

    a_scan_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slotalloc_pkg::S_SCAN && pend_reg) |-> paddr_reg < hw_reg)
        else $error("Scan read a slot above the high-water mark.");

    a_no_write_when_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !mem_we)
        else $error("Slot memory written while no transaction is in work.");

    a_result_loaded_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == slotalloc_pkg::S_RESP && out_free) |=>
            (m_valid && state_reg == slotalloc_pkg::S_IDLE))
        else $error("Result was not loaded into the output register.");

endmodule

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// Slot allocator testbench
// Drives allocate and free transactions through the valid/ready channels and
// checks every result against a cycle-free model of the slot table or, for a
// typed directed row, its listed result. A short directed table goes first,
// then random phases under several settings, most with random idling on both.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SLOTS   = slotalloc_pkg::MAX_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 10_000_000;
    localparam int TAIL_CYCLES = 64;

    typedef struct {
        logic [slotalloc_pkg::INDEX_W-1:0]  slot;
        logic [slotalloc_pkg::SERIAL_W-1:0] serial;
        slotalloc_pkg::status_t             status;
    } slot_rsp_t;

    typedef enum int {
        ROW_REQ,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t                         kind;
        slotalloc_pkg::func_t              func;
        logic [slotalloc_pkg::INDEX_W-1:0] idx;
        logic [slotalloc_pkg::TIME_W-1:0]  value;
        slotalloc_pkg::cfg_reg_t           cfg_sel;
        bit                                typed;
        slot_rsp_t                         rsp;
    } row_t;

    logic                                aclk = 1'b0;
    logic                                aresetn = 1'b0;
    logic                                cfg_wr_en = 1'b0;
    logic [1:0]                          cfg_addr = '0;
    logic [slotalloc_pkg::CFG_W-1:0]     cfg_wr_data = '0;
    logic                                s_valid = 1'b0;
    logic                                s_ready;
    logic                                s_func = 1'b0;
    logic [slotalloc_pkg::INDEX_W-1:0]   s_slot_index = '0;
    logic [slotalloc_pkg::TIME_W-1:0]    s_now_ms = '0;
    logic                                m_valid;
    logic                                m_ready = 1'b0;
    logic [slotalloc_pkg::INDEX_W-1:0]   m_granted_slot;
    logic [slotalloc_pkg::SERIAL_W-1:0]  m_slot_serial;
    logic [2:0]                          m_status;

    // Model of the slot table and its registers.
    bit [slotalloc_pkg::SLOT_W-1:0]   cfg_first = slotalloc_pkg::FIRST_SLOT_RST;
    bit [slotalloc_pkg::SLOT_W-1:0]   cfg_limit = slotalloc_pkg::SLOT_LIMIT_RST;
    bit [slotalloc_pkg::MS_W-1:0]     cfg_grace = slotalloc_pkg::GRACE_RST;
    bit [slotalloc_pkg::MS_W-1:0]     cfg_delay = slotalloc_pkg::REUSE_DELAY_RST;
    bit                               free_bit [MAX_SLOTS];
    bit [slotalloc_pkg::TIME_W-1:0]   freed_at [MAX_SLOTS];
    bit [slotalloc_pkg::SERIAL_W-1:0] serial_no [MAX_SLOTS];
    int unsigned                      high_water = 0;

    slot_rsp_t                         pending_rsp [$];
    logic [slotalloc_pkg::INDEX_W-1:0] held_slots [$];
    logic [slotalloc_pkg::INDEX_W-1:0] last_freed = '0;
    row_t                              directed [$];
    slot_rsp_t                         front_rsp;
    slot_rsp_t                         blank_rsp;

    int src_idle_pct = 0;
    int dst_idle_pct = 0;
    int errors = 0;
    int cycles = 0;
    int n_alloc = 0;
    int n_free = 0;
    int n_writes = 0;
    int status_seen [5];

    slot_allocator_with_reuse_delay #(
        .MAX_SLOTS(MAX_SLOTS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_slot_index  (s_slot_index),
        .s_now_ms      (s_now_ms),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_granted_slot(m_granted_slot),
        .m_slot_serial (m_slot_serial),
        .m_status      (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic bit slot_reusable(int unsigned i,
                                         logic [slotalloc_pkg::TIME_W-1:0] now);
        if (!free_bit[i])
            return 1'b0;
        if (freed_at[i] < cfg_grace)
            return 1'b1;
        return {1'b0, now} > ({1'b0, freed_at[i]} + 33'(cfg_delay));
    endfunction

    function automatic slot_rsp_t table_update(slotalloc_pkg::func_t f,
                                               logic [slotalloc_pkg::INDEX_W-1:0] idx,
                                               logic [slotalloc_pkg::TIME_W-1:0] now);
        slot_rsp_t   r;
        int unsigned i;
        int unsigned cap;
        int unsigned pos;
        r.slot = '0;
        r.serial = '0;
        r.status = slotalloc_pkg::STAT_OK;
        if (f == slotalloc_pkg::FUNC_ALLOC) begin
            for (i = cfg_first; i < high_water && i < MAX_SLOTS; i++) begin
                if (slot_reusable(i, now)) begin
                    free_bit[i] = 1'b0;
                    r.slot = i[slotalloc_pkg::INDEX_W-1:0];
                    r.serial = serial_no[i];
                    return r;
                end
            end
            cap = (cfg_limit > MAX_SLOTS) ? MAX_SLOTS : cfg_limit;
            pos = (high_water > cfg_first) ? high_water : cfg_first;
            if (cfg_limit == 0) begin
                r.status = slotalloc_pkg::STAT_NO_CAPACITY;
            end else if (pos >= cap) begin
                r.status = slotalloc_pkg::STAT_TABLE_FULL;
            end else begin
                high_water = pos + 1;
                free_bit[pos] = 1'b0;
                r.slot = pos[slotalloc_pkg::INDEX_W-1:0];
                r.serial = serial_no[pos];
            end
        end else if (idx >= high_water) begin
            r.status = slotalloc_pkg::STAT_BAD_INDEX;
        end else if (free_bit[idx]) begin
            r.slot = idx;
            r.serial = serial_no[idx];
            r.status = slotalloc_pkg::STAT_ALREADY_FREE;
        end else begin
            free_bit[idx] = 1'b1;
            serial_no[idx] = serial_no[idx] + 1'b1;
            freed_at[idx] = now;
            r.slot = idx;
            r.serial = serial_no[idx];
        end
        return r;
    endfunction

    function automatic row_t op_row(slotalloc_pkg::func_t f, int idx,
                                    logic [slotalloc_pkg::TIME_W-1:0] now);
        row_t r;
        r.kind = ROW_REQ;
        r.func = f;
        r.idx = idx[slotalloc_pkg::INDEX_W-1:0];
        r.value = now;
        r.cfg_sel = slotalloc_pkg::CFG_FIRST_ALLOC_SLOT;
        r.typed = 1'b0;
        r.rsp = blank_rsp;
        return r;
    endfunction

    function automatic row_t op_known(slotalloc_pkg::func_t f, int idx,
                                      logic [slotalloc_pkg::TIME_W-1:0] now,
                                      int slot, int serial, slotalloc_pkg::status_t st);
        row_t r;
        r = op_row(f, idx, now);
        r.typed = 1'b1;
        r.rsp.slot = slot[slotalloc_pkg::INDEX_W-1:0];
        r.rsp.serial = serial[slotalloc_pkg::SERIAL_W-1:0];
        r.rsp.status = st;
        return r;
    endfunction

    function automatic row_t cfg_row(slotalloc_pkg::cfg_reg_t sel, int val);
        row_t r;
        r = op_row(slotalloc_pkg::FUNC_ALLOC, 0, val);
        r.kind = ROW_CFG;
        r.cfg_sel = sel;
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $error("Unexpected result: slot %0d, serial %0d, status %0d",
                       m_granted_slot, m_slot_serial, m_status);
                errors++;
            end else begin
                front_rsp = pending_rsp.pop_front();
                if (m_granted_slot !== front_rsp.slot) begin
                    $error("granted_slot: expected %0d, actual %0d",
                           front_rsp.slot, m_granted_slot);
                    errors++;
                end
                if (m_slot_serial !== front_rsp.serial) begin
                    $error("slot_serial: expected %0d, actual %0d",
                           front_rsp.serial, m_slot_serial);
                    errors++;
                end
                if (m_status !== front_rsp.status) begin
                    $error("status: expected %0d, actual %0d", front_rsp.status, m_status);
                    errors++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= dst_idle_pct);
    end

    task automatic send_request(slotalloc_pkg::func_t f,
                                logic [slotalloc_pkg::INDEX_W-1:0] idx,
                                logic [slotalloc_pkg::TIME_W-1:0] now,
                                bit typed, slot_rsp_t typed_rsp);
        slot_rsp_t r;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= f;
        s_slot_index <= idx;
        s_now_ms <= now;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        r = table_update(f, idx, now);
        pending_rsp.push_back(typed ? typed_rsp : r);
        status_seen[int'(r.status)]++;
        if (f == slotalloc_pkg::FUNC_ALLOC) begin
            n_alloc++;
            if (r.status == slotalloc_pkg::STAT_OK)
                held_slots.push_back(r.slot);
        end else begin
            n_free++;
            if (r.status == slotalloc_pkg::STAT_OK) begin
                last_freed = idx;
                foreach (held_slots[k]) begin
                    if (held_slots[k] == idx) begin
                        held_slots.delete(k);
                        break;
                    end
                end
            end
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(slotalloc_pkg::cfg_reg_t sel,
                             logic [slotalloc_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr <= sel;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        n_writes++;
        case (sel)
            slotalloc_pkg::CFG_FIRST_ALLOC_SLOT: cfg_first = val[slotalloc_pkg::SLOT_W-1:0];
            slotalloc_pkg::CFG_SLOT_LIMIT:       cfg_limit = val[slotalloc_pkg::SLOT_W-1:0];
            slotalloc_pkg::CFG_GRACE_MS:         cfg_grace = val[slotalloc_pkg::MS_W-1:0];
            slotalloc_pkg::CFG_REUSE_DELAY_MS:   cfg_delay = val[slotalloc_pkg::MS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(int first, int limit, int grace, int delay);
        wait_idle();
        write_reg(slotalloc_pkg::CFG_FIRST_ALLOC_SLOT, first[slotalloc_pkg::CFG_W-1:0]);
        write_reg(slotalloc_pkg::CFG_SLOT_LIMIT, limit[slotalloc_pkg::CFG_W-1:0]);
        write_reg(slotalloc_pkg::CFG_GRACE_MS, grace[slotalloc_pkg::CFG_W-1:0]);
        write_reg(slotalloc_pkg::CFG_REUSE_DELAY_MS, delay[slotalloc_pkg::CFG_W-1:0]);
    endtask

    task automatic run_phase(int count);
        logic [slotalloc_pkg::TIME_W-1:0]  now;
        logic [slotalloc_pkg::INDEX_W-1:0] idx;
        slotalloc_pkg::func_t              f;
        int                                op;
        int                                step_max;
        if ($urandom_range(1) == 1)
            now = $urandom_range(0, 2 * cfg_grace);
        else
            now = $urandom();
        step_max = cfg_delay / 4 + 4;
        repeat (count) begin
            if ($urandom_range(99) < 5)
                now = $urandom();
            else
                now = now + $urandom_range(0, step_max);
            idx = $urandom_range(1023);
            f = slotalloc_pkg::FUNC_ALLOC;
            op = $urandom_range(99);
            if (op >= 93) begin
                f = slotalloc_pkg::FUNC_FREE;
                idx = last_freed;
            end else if (op >= 85) begin
                f = slotalloc_pkg::FUNC_FREE;
            end else if (op >= 50 && held_slots.size() != 0) begin
                f = slotalloc_pkg::FUNC_FREE;
                idx = held_slots[$urandom_range(held_slots.size() - 1)];
            end
            send_request(f, idx, now, 1'b0, blank_rsp);
        end
    endtask

    initial begin
        blank_rsp.slot = '0;
        blank_rsp.serial = '0;
        blank_rsp.status = slotalloc_pkg::STAT_OK;
        foreach (status_seen[k])
            status_seen[k] = 0;

        directed.push_back(op_known(slotalloc_pkg::FUNC_FREE, 0, 32'd0, 0, 0,
                                    slotalloc_pkg::STAT_BAD_INDEX));
        directed.push_back(op_known(slotalloc_pkg::FUNC_FREE, 1023, 32'hFFFF_FFFF, 0, 0,
                                    slotalloc_pkg::STAT_BAD_INDEX));
        directed.push_back(op_known(slotalloc_pkg::FUNC_ALLOC, 0, 32'd0, 1, 0,
                                    slotalloc_pkg::STAT_OK));
        directed.push_back(op_known(slotalloc_pkg::FUNC_ALLOC, 1023, 32'd0, 2, 0,
                                    slotalloc_pkg::STAT_OK));
        directed.push_back(op_known(slotalloc_pkg::FUNC_FREE, 1, 32'd100, 1, 1,
                                    slotalloc_pkg::STAT_OK));
        directed.push_back(op_known(slotalloc_pkg::FUNC_FREE, 1, 32'd200, 1, 1,
                                    slotalloc_pkg::STAT_ALREADY_FREE));
        directed.push_back(op_known(slotalloc_pkg::FUNC_ALLOC, 0, 32'd100, 1, 1,
                                    slotalloc_pkg::STAT_OK));
        directed.push_back(op_known(slotalloc_pkg::FUNC_FREE, 2, 32'd5000, 2, 1,
                                    slotalloc_pkg::STAT_OK));
        directed.push_back(op_known(slotalloc_pkg::FUNC_ALLOC, 0, 32'd5500, 3, 0,
                                    slotalloc_pkg::STAT_OK));
        directed.push_back(op_known(slotalloc_pkg::FUNC_ALLOC, 0, 32'd5501, 2, 1,
                                    slotalloc_pkg::STAT_OK));
        directed.push_back(op_row(slotalloc_pkg::FUNC_FREE, 3, 32'hFFFF_FFF0));
        directed.push_back(op_row(slotalloc_pkg::FUNC_ALLOC, 0, 32'hFFFF_FFFF));
        directed.push_back(op_row(slotalloc_pkg::FUNC_FREE, 0, 32'd0));
        directed.push_back(cfg_row(slotalloc_pkg::CFG_SLOT_LIMIT, 0));
        directed.push_back(op_known(slotalloc_pkg::FUNC_ALLOC, 0, 32'd5, 0, 0,
                                    slotalloc_pkg::STAT_NO_CAPACITY));
        directed.push_back(cfg_row(slotalloc_pkg::CFG_SLOT_LIMIT, 6));
        directed.push_back(op_row(slotalloc_pkg::FUNC_ALLOC, 0, 32'd5));
        directed.push_back(op_known(slotalloc_pkg::FUNC_ALLOC, 0, 32'd6, 0, 0,
                                    slotalloc_pkg::STAT_TABLE_FULL));
        directed.push_back(cfg_row(slotalloc_pkg::CFG_FIRST_ALLOC_SLOT, 1024));
        directed.push_back(op_known(slotalloc_pkg::FUNC_ALLOC, 0, 32'd7, 0, 0,
                                    slotalloc_pkg::STAT_TABLE_FULL));
        directed.push_back(cfg_row(slotalloc_pkg::CFG_FIRST_ALLOC_SLOT, 1));
        directed.push_back(cfg_row(slotalloc_pkg::CFG_SLOT_LIMIT, 1024));
        directed.push_back(cfg_row(slotalloc_pkg::CFG_GRACE_MS, 65535));
        directed.push_back(cfg_row(slotalloc_pkg::CFG_REUSE_DELAY_MS, 0));
        directed.push_back(op_row(slotalloc_pkg::FUNC_FREE, 4, 32'd70000));
        directed.push_back(op_row(slotalloc_pkg::FUNC_ALLOC, 0, 32'd70000));
        directed.push_back(op_row(slotalloc_pkg::FUNC_ALLOC, 0, 32'd70001));
        directed.push_back(op_row(slotalloc_pkg::FUNC_FREE, 6, 32'd70002));
        directed.push_back(op_row(slotalloc_pkg::FUNC_ALLOC, 0, 32'd70003));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        src_idle_pct = 20;
        dst_idle_pct = 88;
        foreach (directed[k]) begin
            if (directed[k].kind == ROW_CFG) begin
                wait_idle();
                write_reg(directed[k].cfg_sel, directed[k].value[slotalloc_pkg::CFG_W-1:0]);
            end else begin
                send_request(directed[k].func, directed[k].idx, directed[k].value,
                             directed[k].typed, directed[k].rsp);
            end
        end

        set_regs(1, 16, 2000, 500);
        run_phase(150);
        set_regs(1, 40, 0, 0);
        run_phase(150);
        set_regs(3, 64, 65535, 65535);
        run_phase(150);

        src_idle_pct = 88;
        dst_idle_pct = 20;
        set_regs(5, 0, 100, 50);
        run_phase(100);
        set_regs(2, 64, 1000, 20);
        run_phase(170);
        set_regs(200, 1024, 0, 300);
        run_phase(170);

        src_idle_pct = 0;
        dst_idle_pct = 0;
        set_regs(1000, 1024, 30000, 1000);
        run_phase(170);
        set_regs(1024, 1024, 2000, 500);
        run_phase(80);
        set_regs(1010, 1024, $urandom_range(65535), $urandom_range(65535));
        run_phase(170);

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d transactions (%0d allocate, %0d free) and %0d register writes.",
                 n_alloc + n_free, n_alloc, n_free, n_writes);
        $display("Results: %0d ok, %0d already free, %0d no capacity, %0d full, %0d bad index.",
                 status_seen[slotalloc_pkg::STAT_OK],
                 status_seen[slotalloc_pkg::STAT_ALREADY_FREE],
                 status_seen[slotalloc_pkg::STAT_NO_CAPACITY],
                 status_seen[slotalloc_pkg::STAT_TABLE_FULL],
                 status_seen[slotalloc_pkg::STAT_BAD_INDEX]);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
